// ----- design/mse_pkg.sv -----
`timescale 1ns / 1ps
// Shared sizes, command codes and beat/control types for the MIPS subset execute block.
package mse_pkg;

    localparam int REG_COUNT      = 32;
    localparam int REG_W          = $clog2(REG_COUNT);
    localparam int DATA_BYTES_DEF = 64;
    localparam int CMD_W          = 4;
    localparam int IMM_W          = 14;
    localparam int LINE_W         = 14;
    localparam int WORD_W         = 32;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ADD  = 4'd0;
    localparam logic [CMD_W-1:0] CMD_SUB  = 4'd1;
    localparam logic [CMD_W-1:0] CMD_MUL  = 4'd2;
    localparam logic [CMD_W-1:0] CMD_BEQ  = 4'd3;
    localparam logic [CMD_W-1:0] CMD_BNE  = 4'd4;
    localparam logic [CMD_W-1:0] CMD_SLT  = 4'd5;
    localparam logic [CMD_W-1:0] CMD_J    = 4'd6;
    localparam logic [CMD_W-1:0] CMD_LW   = 4'd7;
    localparam logic [CMD_W-1:0] CMD_SW   = 4'd8;
    localparam logic [CMD_W-1:0] CMD_ADDI = 4'd9;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [REG_W-1:0]  first_reg;
        logic [REG_W-1:0]  second_reg;
        logic [REG_W-1:0]  third_reg;
        logic [IMM_W-1:0]  immediate;
        logic [LINE_W-1:0] target_line;
    } mse_instr_t;

    typedef struct packed {
        logic              taken;
        logic [LINE_W-1:0] next_line;
        logic              reg_written;
        logic [REG_W-1:0]  written_index;
        logic [WORD_W-1:0] written_value;
        logic [WORD_W-1:0] executed_count;
    } mse_result_t;

    // Register file write request
    typedef struct packed {
        logic              en;
        logic [REG_W-1:0]  idx;
        logic [WORD_W-1:0] val;
    } mse_rf_wr_t;

    // Data store word write request (offset of the most significant byte)
    typedef struct packed {
        logic              en;
        logic [REG_W-1:0]  offset;
        logic [WORD_W-1:0] word;
    } mse_st_wr_t;

endpackage

// ----- design/mips_subset_execute.sv -----
`timescale 1ns / 1ps
// Top level: two-stage execute of one decoded MIPS subset instruction per beat.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+----------------------------------
//  instr    | instr_valid / instr_ready   | mse_instr_t  (decoded instruction)
//  result   | result_valid / result_ready | mse_result_t (outcome and count)
//
// One instruction per cycle sustained while result_ready keeps the result slot free.
// The first stage reads register file and data store banks (registered RAM reads);
// the second stage executes, writes back and loads the result register.
// Same-cycle write/read hazards are covered by a last-write bypass.
// Reset clears valid bits and counters; no clearing pass, ready after reset.
// A stalled result holds the execute stage; a free result slot keeps input open.
module mips_subset_execute
    import mse_pkg::*;
#(
    parameter int DATA_BYTES = DATA_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        instr_valid,
    output logic        instr_ready,
    input  mse_instr_t  instr,
    output logic        result_valid,
    input  logic        result_ready,
    output mse_result_t result
);

    logic              ex_valid_reg;
    mse_instr_t        ex_reg;
    logic              out_valid_reg;
    mse_result_t       out_reg;
    logic [WORD_W-1:0] count_reg;

    logic              out_free;
    logic              ex_adv;
    logic              accept;
    logic              src_second;
    logic              src_third;
    logic [REG_W-1:0]  raddr0;
    logic [REG_W-1:0]  raddr1;
    logic [WORD_W-1:0] op0;
    logic [WORD_W-1:0] op1;
    logic [WORD_W-1:0] load_word;
    logic [WORD_W-1:0] count_next;
    mse_result_t       alu_res;
    mse_rf_wr_t        alu_rf_wr;
    mse_st_wr_t        alu_st_wr;
    mse_rf_wr_t        rf_wr;
    mse_st_wr_t        st_wr;

    // Pipeline flow control
    assign out_free    = !out_valid_reg || result_ready;
    assign ex_adv      = ex_valid_reg && out_free;
    assign instr_ready = !ex_valid_reg || ex_adv;
    assign accept      = instr_valid && instr_ready;

    // Pick read ports: ADD/SUB/MUL read second/third, ADDI reads second, compares and stores read first/second
    assign src_second = (instr.cmd == CMD_ADD) || (instr.cmd == CMD_SUB) ||
                        (instr.cmd == CMD_MUL) || (instr.cmd == CMD_ADDI);
    assign src_third  = (instr.cmd == CMD_ADD) || (instr.cmd == CMD_SUB) ||
                        (instr.cmd == CMD_MUL);
    assign raddr0     = src_second ? instr.second_reg : instr.first_reg;
    assign raddr1     = src_third ? instr.third_reg : instr.second_reg;

    // Commit writes only when the execute stage advances
    always_comb
    begin
        rf_wr    = alu_rf_wr;
        rf_wr.en = alu_rf_wr.en && ex_adv;
        st_wr    = alu_st_wr;
        st_wr.en = alu_st_wr.en && ex_adv;
    end

    assign count_next = count_reg + 1'b1;

    mse_regfile u_regfile (
        .clk    (clk),
        .rst_n  (rst_n),
        .re     (accept),
        .raddr0 (raddr0),
        .raddr1 (raddr1),
        .wr     (rf_wr),
        .rdata0 (op0),
        .rdata1 (op1)
    );

    mse_dstore #(.DATA_BYTES(DATA_BYTES)) u_dstore (
        .clk       (clk),
        .rst_n     (rst_n),
        .re        (accept),
        .roffset   (instr.second_reg),
        .wr        (st_wr),
        .load_word (load_word)
    );

    mse_alu u_alu (
        .ex         (ex_reg),
        .op0        (op0),
        .op1        (op1),
        .load_word  (load_word),
        .count_next (count_next),
        .res        (alu_res),
        .rf_wr      (alu_rf_wr),
        .st_wr      (alu_st_wr)
    );

    // Advance valid flags and the instruction count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            if (instr_ready)
            begin
                ex_valid_reg <= instr_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= ex_valid_reg;
            end
            if (ex_adv)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Hold payload in the execute and result registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ex_reg <= instr;
        end
        if (ex_adv)
        begin
            out_reg <= alu_res;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // A stalled execute stage must block new beats
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (ex_valid_reg && !out_free) |-> !instr_ready)
        else $error("input accepted while execute stage stalled");

    // Each result beat carries the count one past the previous total
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        ex_adv |=> (out_valid_reg && out_reg.executed_count == $past(count_reg) + 1'b1))
        else $error("executed count out of step");

    // No register write means zero index and value
    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.reg_written) |->
        (out_reg.written_index == '0 && out_reg.written_value == '0))
        else $error("write fields set without a register write");

    // Next line is zero unless redirected
    a_line_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.taken) |-> (out_reg.next_line == '0))
        else $error("next line set without a taken branch");

endmodule

// ----- design/mse_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module mse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and read; a read at the written address returns the old word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/mse_regfile.sv -----
`timescale 1ns / 1ps
// Register file: two read ports on replicated RAMs, reset valid bits and last-write bypass.
module mse_regfile
    import mse_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              re,
    input  logic [REG_W-1:0]  raddr0,
    input  logic [REG_W-1:0]  raddr1,
    input  mse_rf_wr_t        wr,
    output logic [WORD_W-1:0] rdata0,
    output logic [WORD_W-1:0] rdata1
);

    logic [WORD_W-1:0]    ram_q0;
    logic [WORD_W-1:0]    ram_q1;
    logic [REG_W-1:0]     raddr0_reg;
    logic [REG_W-1:0]     raddr1_reg;
    logic [REG_COUNT-1:0] valid_reg;
    mse_rf_wr_t           last_reg;

    mse_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_ram0 (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.idx),
        .wdata (wr.val),
        .re    (re),
        .raddr (raddr0),
        .rdata (ram_q0)
    );

    mse_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_ram1 (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.idx),
        .wdata (wr.val),
        .re    (re),
        .raddr (raddr1),
        .rdata (ram_q1)
    );

    // Hold read addresses alongside the RAM output
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            raddr0_reg <= raddr0;
            raddr1_reg <= raddr1;
        end
    end

    // Track written entries and keep the most recent write for bypass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            last_reg  <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.idx] <= 1'b1;
            last_reg          <= wr;
        end
    end

    // Resolve: latest write wins, unwritten entries read as zero
    assign rdata0 = (last_reg.en && last_reg.idx == raddr0_reg) ? last_reg.val :
                    (valid_reg[raddr0_reg] ? ram_q0 : '0);
    assign rdata1 = (last_reg.en && last_reg.idx == raddr1_reg) ? last_reg.val :
                    (valid_reg[raddr1_reg] ? ram_q1 : '0);

endmodule

// ----- design/mse_dstore.sv -----
`timescale 1ns / 1ps
// Byte data store: four interleaved byte banks for unaligned 4-byte load and store.
module mse_dstore
    import mse_pkg::*;
#(
    parameter int DATA_BYTES = DATA_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              re,
    input  logic [REG_W-1:0]  roffset,
    input  mse_st_wr_t        wr,
    output logic [WORD_W-1:0] load_word
);

    localparam int ROWS   = (DATA_BYTES + 3) / 4;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    // Highest byte address reachable is the largest offset plus three
    localparam int ADDR_W = $clog2(REG_COUNT + 3);
    localparam int VROWS  = ((REG_COUNT + 2) / 4) + 1;
    localparam int VR_W   = $clog2(VROWS);

    logic [7:0] bank_byte [4];
    logic [1:0] roff_lo_reg;

    // Hold low offset bits to steer banks into word byte lanes
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            roff_lo_reg <= roffset[1:0];
        end
    end

    for (genvar j = 0; j < 4; j++)
    begin : g_bank
        logic [1:0]        rk;
        logic [1:0]        wk;
        logic [ADDR_W-1:0] raddr;
        logic [ADDR_W-1:0] waddr;
        logic [VR_W-1:0]   rrow;
        logic [VR_W-1:0]   wrow;
        logic [7:0]        wbyte;
        logic [7:0]        ram_q;
        logic [VR_W-1:0]   rrow_reg;
        logic [VROWS-1:0]  valid_reg;
        logic              last_en_reg;
        logic [VR_W-1:0]   last_row_reg;
        logic [7:0]        last_byte_reg;

        // Byte position within the word that falls in this bank
        assign rk    = 2'(j) - roffset[1:0];
        assign wk    = 2'(j) - wr.offset[1:0];
        assign raddr = ADDR_W'(roffset) + ADDR_W'(rk);
        assign waddr = ADDR_W'(wr.offset) + ADDR_W'(wk);
        assign rrow  = raddr[2 +: VR_W];
        assign wrow  = waddr[2 +: VR_W];
        assign wbyte = wr.word[8 * (2'd3 - wk) +: 8];

        mse_ram #(.WIDTH(8), .DEPTH(ROWS)) u_bank (
            .clk   (clk),
            .we    (wr.en),
            .waddr (ROW_W'(wrow)),
            .wdata (wbyte),
            .re    (re),
            .raddr (ROW_W'(rrow)),
            .rdata (ram_q)
        );

        always_ff @(posedge clk)
        begin
            if (re)
            begin
                rrow_reg <= rrow;
            end
        end

        // Track written rows and keep the last byte written for bypass
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg     <= '0;
                last_en_reg   <= 1'b0;
                last_row_reg  <= '0;
                last_byte_reg <= '0;
            end
            else if (wr.en)
            begin
                valid_reg[wrow] <= 1'b1;
                last_en_reg     <= 1'b1;
                last_row_reg    <= wrow;
                last_byte_reg   <= wbyte;
            end
        end

        assign bank_byte[j] = (last_en_reg && last_row_reg == rrow_reg) ? last_byte_reg :
                              (valid_reg[rrow_reg] ? ram_q : 8'h00);
    end

    // Assemble the word, most significant byte at the lowest address
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            load_word[8 * (3 - k) +: 8] = bank_byte[roff_lo_reg + 2'(k)];
        end
    end

endmodule

// ----- design/mse_alu.sv -----
`timescale 1ns / 1ps
// Execute logic: arithmetic, compare, branch decision and load/store requests.
module mse_alu
    import mse_pkg::*;
(
    input  mse_instr_t        ex,
    input  logic [WORD_W-1:0] op0,
    input  logic [WORD_W-1:0] op1,
    input  logic [WORD_W-1:0] load_word,
    input  logic [WORD_W-1:0] count_next,
    output mse_result_t       res,
    output mse_rf_wr_t        rf_wr,
    output mse_st_wr_t        st_wr
);

    // Decode command and form the result beat
    always_comb
    begin
        res                = '0;
        rf_wr              = '0;
        st_wr              = '0;
        res.executed_count = count_next;
        unique case (ex.cmd)
            CMD_ADD:
            begin
                rf_wr.en  = 1'b1;
                rf_wr.idx = ex.first_reg;
                rf_wr.val = op0 + op1;
            end
            CMD_SUB:
            begin
                rf_wr.en  = 1'b1;
                rf_wr.idx = ex.first_reg;
                rf_wr.val = op0 - op1;
            end
            CMD_MUL:
            begin
                rf_wr.en  = 1'b1;
                rf_wr.idx = ex.first_reg;
                rf_wr.val = op0 * op1;
            end
            CMD_BEQ:
            begin
                res.taken = (op0 == op1);
            end
            CMD_BNE:
            begin
                res.taken = (op0 != op1);
            end
            CMD_SLT:
            begin
                rf_wr.en  = 1'b1;
                rf_wr.idx = ex.third_reg;
                rf_wr.val = {{(WORD_W-1){1'b0}}, (op0 < op1)};
            end
            CMD_J:
            begin
                res.taken = 1'b1;
            end
            CMD_LW:
            begin
                rf_wr.en  = 1'b1;
                rf_wr.idx = ex.first_reg;
                rf_wr.val = load_word;
            end
            CMD_SW:
            begin
                st_wr.en     = 1'b1;
                st_wr.offset = ex.second_reg;
                st_wr.word   = op0;
            end
            CMD_ADDI:
            begin
                rf_wr.en  = 1'b1;
                rf_wr.idx = ex.first_reg;
                rf_wr.val = op0 + WORD_W'(ex.immediate);
            end
            default:
            begin
                res.taken = 1'b0;
            end
        endcase
        res.next_line     = res.taken ? ex.target_line : '0;
        res.reg_written   = rf_wr.en;
        res.written_index = rf_wr.idx;
        res.written_value = rf_wr.val;
    end

endmodule
